// File: rtl/srrip_pkg.sv
// Shared types and constants for the SRRIP cache tag store.
package srrip_pkg;

	// Fixed field widths.
	localparam int TAG_W      = 32;
	localparam int CNT_W      = 32;
	localparam int RRPV_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int SHIFT_W    = 6;

	// Largest block offset honored; larger settings saturate to it.
	localparam logic [4:0] OFFSET_MAX = 5'd16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
	localparam logic [3:0] INDEX_BITS_RST  = 4'd6;
	localparam logic [4:0] WAYS_IN_USE_RST = 5'd4;

	// Event counter slots.
	localparam int CNT_NUM        = 6;
	localparam int CNT_ACCESS     = 0;
	localparam int CNT_LOAD_HIT   = 1;
	localparam int CNT_STORE_HIT  = 2;
	localparam int CNT_LOAD_MISS  = 3;
	localparam int CNT_STORE_MISS = 4;
	localparam int CNT_DIRTY_EVCT = 5;

	// RRPV maxima for the two supported widths.
	localparam logic [RRPV_W-1:0] RRPV_MAX_WIDE   = 2'd3;
	localparam logic [RRPV_W-1:0] RRPV_MAX_NARROW = 2'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// One way of a set.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              valid;
		logic              dirty;
		logic [RRPV_W-1:0] rrpv;
	} line_t;

	// Outcome of one access, handed to the event counters.
	typedef struct packed {
		logic store;
		logic hit;
		logic dirty_ev;
	} ev_t;

endpackage

// File: rtl/srrip_tag_ram.sv
// Single-port-style set memory: one row per set, registered read data.
module srrip_tag_ram #(
	parameter int ADDR_W = 12,
	parameter int DEPTH  = 4096,
	parameter int ROW_W  = 576
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [ROW_W-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ROW_W-1:0]  wr_data
);

	logic [ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// The controller never reads and writes the memory in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) rd_en |-> !wr_en)
		else $error("set memory read and write in the same cycle");

endmodule

// File: rtl/srrip_set_update.sv
// Lookup, aging, victim choice and row rewrite for one set.
module srrip_set_update
	import srrip_pkg::*;
#(
	parameter int NWAYS = 16
) (
	input  line_t [NWAYS-1:0] row,
	input  logic [TAG_W-1:0]  tag,
	input  logic              store,
	input  logic [NWAYS-1:0]  way_en,
	input  logic [RRPV_W-1:0] rrpv_max,
	output line_t [NWAYS-1:0] row_next,
	output ev_t               ev
);

	localparam int WAY_W = (NWAYS > 1) ? $clog2(NWAYS) : 1;

	logic [NWAYS-1:0]              hit_vec;
	logic [NWAYS-1:0]              cand_vec;
	logic [NWAYS-1:0]              is3, is2, is1;
	logic [NWAYS-1:0][RRPV_W-1:0]  r_clamp;
	logic [NWAYS-1:0][RRPV_W-1:0]  aged;
	logic [RRPV_W-1:0]             highest;
	logic [RRPV_W-1:0]             delta;
	logic [WAY_W-1:0]              hit_way;
	logic [WAY_W-1:0]              victim;
	logic                          hit;

	// Per-way compare and RRPV clamp.
	always_comb begin
		for (int k = 0; k < NWAYS; k++) begin
			hit_vec[k] = way_en[k] && row[k].valid && (row[k].tag == tag);
			r_clamp[k] = (row[k].rrpv > rrpv_max) ? rrpv_max : row[k].rrpv;
			is3[k]     = way_en[k] && (r_clamp[k] == 2'd3);
			is2[k]     = way_en[k] && (r_clamp[k] == 2'd2);
			is1[k]     = way_en[k] && (r_clamp[k] == 2'd1);
		end
	end

	assign hit = |hit_vec;

	always_comb begin
		if (|is3) begin
			highest = 2'd3;
		end else if (|is2) begin
			highest = 2'd2;
		end else if (|is1) begin
			highest = 2'd1;
		end else begin
			highest = 2'd0;
		end
	end

	// Aging all ways until one reaches the maximum is a single add of the gap.
	assign delta = rrpv_max - highest;

	always_comb begin
		for (int k = 0; k < NWAYS; k++) begin
			aged[k]     = r_clamp[k] + delta;
			cand_vec[k] = way_en[k] && (r_clamp[k] == highest);
		end
	end

	// Lowest-numbered way wins in both searches.
	always_comb begin
		hit_way = '0;
		victim  = '0;
		for (int k = NWAYS - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				hit_way = WAY_W'(k);
			end
			if (cand_vec[k]) begin
				victim = WAY_W'(k);
			end
		end
	end

	always_comb begin
		row_next = row;
		if (hit) begin
			row_next[hit_way].rrpv  = '0;
			row_next[hit_way].dirty = row[hit_way].dirty | store;
		end else begin
			for (int k = 0; k < NWAYS; k++) begin
				if (way_en[k]) begin
					row_next[k].rrpv = aged[k];
				end
			end
			row_next[victim].tag   = tag;
			row_next[victim].valid = 1'b1;
			row_next[victim].dirty = store;
			row_next[victim].rrpv  = rrpv_max - 2'd1;
		end
	end

	assign ev.store    = store;
	assign ev.hit      = hit;
	assign ev.dirty_ev = !hit && row[victim].valid && row[victim].dirty;

endmodule

// File: rtl/srrip_counters.sv
// Six saturating event counters.
module srrip_counters
	import srrip_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd,
	input  ev_t                            ev,
	output logic [CNT_NUM-1:0][CNT_W-1:0]  cnt_q
);

	logic [CNT_NUM-1:0] inc;

	always_comb begin
		inc                 = '0;
		inc[CNT_ACCESS]     = 1'b1;
		inc[CNT_LOAD_HIT]   = ev.hit && !ev.store;
		inc[CNT_STORE_HIT]  = ev.hit && ev.store;
		inc[CNT_LOAD_MISS]  = !ev.hit && !ev.store;
		inc[CNT_STORE_MISS] = !ev.hit && ev.store;
		inc[CNT_DIRTY_EVCT] = ev.dirty_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd) begin
			for (int i = 0; i < CNT_NUM; i++) begin
				if (inc[i] && (cnt_q[i] != '1)) begin
					cnt_q[i] <= cnt_q[i] + CNT_W'(1);
				end
			end
		end
	end

endmodule

// File: rtl/srrip_cache_tag_store_core.sv
// Top level of the SRRIP cache tag store: control, set memory, counters, result register.
// A request's set row is read on acceptance; the update and write-back of that row happen
// when the result register loads, once the result channel is free. No new request is taken
// until that read-modify-write of one set row in the set memory is complete.
// Reset clears the control state and counters, then sweeps every row of the set memory
// (2**MAX_SET_BITS rows, 4096 by default); every configuration write to a defined register
// starts the same sweep again. No request is taken while a sweep runs.
module srrip_cache_tag_store_core
	import srrip_pkg::*;
#(
	parameter int MAX_SET_BITS = 12,
	parameter int MAX_WAYS     = 16,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// Request channel.
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  opcode,
	input  logic [ADDR_WIDTH-1:0] address,

	// Result channel.
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  hit,
	output logic                  dirty_eviction,
	output logic [CNT_W-1:0]      access_count,
	output logic [CNT_W-1:0]      load_hit_count,
	output logic [CNT_W-1:0]      store_hit_count,
	output logic [CNT_W-1:0]      load_miss_count,
	output logic [CNT_W-1:0]      store_miss_count,
	output logic [CNT_W-1:0]      dirty_eviction_count
);

	// Set memory geometry. One row holds every way of a set.
	localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int ROW_W  = MAX_WAYS * $bits(line_t);
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int AEXT_W = (ADDR_WIDTH > TAG_W) ? ADDR_WIDTH : TAG_W;

	state_t state_q, state_d;

	// Configuration registers.
	logic [4:0] offset_bits_q;
	logic [3:0] index_bits_q;
	logic [4:0] ways_in_use_q;

	// Effective settings after saturation.
	logic [4:0]          ob;
	logic [4:0]          ib;
	logic [WCNT_W-1:0]   eff_ways;
	logic [RRPV_W-1:0]   rrpv_max;
	logic [MAX_WAYS-1:0] way_en;

	// Address split.
	logic [AEXT_W-1:0]  addr_ext;
	logic [AEXT_W-1:0]  addr_sh;
	logic [AEXT_W-1:0]  tag_sh;
	logic [SET_W-1:0]   set_mask;
	logic [SET_W-1:0]   set_idx;
	logic [TAG_W-1:0]   tag_idx;

	// Access in flight.
	logic [SET_W-1:0]   set_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               store_s1;

	// Sweep and memory ports.
	logic [SET_W-1:0]   clr_idx_q;
	logic               clr_last;
	logic               cfg_clear;
	logic               req_accept;
	logic               out_load;
	logic               mem_we;
	logic [SET_W-1:0]   mem_waddr;
	line_t [MAX_WAYS-1:0] row_rd;
	line_t [MAX_WAYS-1:0] row_upd;
	line_t [MAX_WAYS-1:0] row_clr;
	line_t [MAX_WAYS-1:0] mem_wdata;
	ev_t                ev;

	// Result register; the counters double as the count fields, since they only move
	// when this register is loaded.
	logic rsp_valid_q;
	logic hit_q;
	logic dirty_ev_q;
	logic [CNT_NUM-1:0][CNT_W-1:0] cnt_q;

	//-------------------------------------------------------------------------------------
	// Configuration
	//-------------------------------------------------------------------------------------
	// Only writes to a defined register clear the store; other indexes are ignored.
	assign cfg_clear = cfg_we && ((cfg_index == CFG_OFFSET_BITS) ||
		(cfg_index == CFG_INDEX_BITS) || (cfg_index == CFG_WAYS_IN_USE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data[3:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ob = (offset_bits_q > OFFSET_MAX) ? OFFSET_MAX : offset_bits_q;
	assign ib = ({1'b0, index_bits_q} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
		: {1'b0, index_bits_q};

	// A setting of zero ways behaves as one; anything past the array size saturates.
	always_comb begin
		if (ways_in_use_q == '0) begin
			eff_ways = WCNT_W'(1);
		end else if ({1'b0, ways_in_use_q} > 6'(MAX_WAYS)) begin
			eff_ways = WCNT_W'(MAX_WAYS);
		end else begin
			eff_ways = WCNT_W'(ways_in_use_q);
		end
	end

	// Two-bit RRPV when more than two ways are in use, one-bit otherwise.
	assign rrpv_max = (eff_ways > WCNT_W'(2)) ? RRPV_MAX_WIDE : RRPV_MAX_NARROW;

	always_comb begin
		for (int k = 0; k < MAX_WAYS; k++) begin
			way_en[k] = (WCNT_W'(k) < eff_ways);
		end
	end

	//-------------------------------------------------------------------------------------
	// Address split: offset below, set index above it, tag above that.
	//-------------------------------------------------------------------------------------
	assign addr_ext = AEXT_W'(address);
	assign addr_sh  = addr_ext >> ob;
	assign tag_sh   = addr_ext >> (SHIFT_W'(ob) + SHIFT_W'(ib));
	assign set_mask = ~({SET_W{1'b1}} << ib);
	assign set_idx  = addr_sh[SET_W-1:0] & set_mask;
	assign tag_idx  = tag_sh[TAG_W-1:0];

	//-------------------------------------------------------------------------------------
	// Control
	//-------------------------------------------------------------------------------------
	assign req_accept = req_valid && !req_stall;
	assign out_load   = (state_q == ST_UPDATE) && (!rsp_valid_q || !rsp_stall);
	assign clr_last   = (clr_idx_q == SET_W'(SETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		// A new geometry invalidates everything, so the sweep restarts.
		if (cfg_clear) begin
			state_d = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cfg_clear) begin
			clr_idx_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_idx_q <= clr_idx_q + SET_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			set_s1   <= set_idx;
			tag_s1   <= tag_idx;
			store_s1 <= opcode;
		end
	end

	//-------------------------------------------------------------------------------------
	// Set memory and update logic
	//-------------------------------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < MAX_WAYS; k++) begin
			row_clr[k].tag   = '0;
			row_clr[k].valid = 1'b0;
			row_clr[k].dirty = 1'b0;
			row_clr[k].rrpv  = rrpv_max;
		end
	end

	assign mem_we    = (state_q == ST_CLEAR) || out_load;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : set_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? row_clr : row_upd;

	srrip_tag_ram #(
		.ADDR_W (SET_W),
		.DEPTH  (SETS),
		.ROW_W  (ROW_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (req_accept),
		.rd_addr (set_idx),
		.rd_data (row_rd),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	srrip_set_update #(
		.NWAYS (MAX_WAYS)
	) u_upd (
		.row      (row_rd),
		.tag      (tag_s1),
		.store    (store_s1),
		.way_en   (way_en),
		.rrpv_max (rrpv_max),
		.row_next (row_upd),
		.ev       (ev)
	);

	srrip_counters u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (out_load),
		.ev     (ev),
		.cnt_q  (cnt_q)
	);

	//-------------------------------------------------------------------------------------
	// Result register
	//-------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q      <= ev.hit;
			dirty_ev_q <= ev.dirty_ev;
		end
	end

	assign rsp_valid            = rsp_valid_q;
	assign hit                  = hit_q;
	assign dirty_eviction       = dirty_ev_q;
	assign access_count         = cnt_q[CNT_ACCESS];
	assign load_hit_count       = cnt_q[CNT_LOAD_HIT];
	assign store_hit_count      = cnt_q[CNT_STORE_HIT];
	assign load_miss_count      = cnt_q[CNT_LOAD_MISS];
	assign store_miss_count     = cnt_q[CNT_STORE_MISS];
	assign dirty_eviction_count = cnt_q[CNT_DIRTY_EVCT];

	//-------------------------------------------------------------------------------------
	// Assertions
	//-------------------------------------------------------------------------------------
	// A configuration write always blocks requests in the following cycle (sweep).
	a_cfg_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clear |=> req_stall)
		else $error("request window open right after a configuration write");

	// Every result beat loaded advances the access count unless it is saturated.
	a_access_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ((access_count == $past(access_count) + CNT_W'(1)) ||
		($past(access_count) == '1)))
		else $error("access count out of step with result beats");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(hit && dirty_eviction))
		else $error("result beat reports both hit and dirty eviction");

	// A waiting result beat keeps the counters frozen; checked on the dirty eviction count.
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> $stable(dirty_eviction_count))
		else $error("counters moved while a result beat was stalled");

endmodule
